// ===== design/spa_pkg.sv =====
// spa_pkg: shared constants, codes and types of the slot pool allocator
// used by every design file but spa_link_ram and by the checker; depends on nothing
package spa_pkg;

  localparam int unsigned POOL_UNITS = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned PTR_W      = $clog2(POOL_UNITS + 1);
  localparam int unsigned LINK_DEPTH = 1 << ADDR_W;
  localparam int unsigned LINK_W     = ADDR_W + 1;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PROD_W     = STEP_W + CNT_W;
  localparam int unsigned END_W      = ((PROD_W > PTR_W) ? PROD_W : PTR_W) + 1;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [STEP_W-1:0] SLOT_UNITS_RST  = STEP_W'(1);
  localparam logic [CNT_W-1:0]  BLOCK_SLOTS_RST = CNT_W'(64);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_OOM   = 2'd1,
    ST_FREED = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  typedef enum logic {
    REG_SLOT_UNITS  = 1'b0,
    REG_BLOCK_SLOTS = 1'b1
  } reg_e;

  typedef struct packed {
    logic [STEP_W-1:0] slot_units;
    logic [CNT_W-1:0]  block_slots;
  } cfg_t;

endpackage

// ===== design/spa_if.sv =====
// spa_if: request and response channels of the slot pool allocator
// depends on spa_pkg for field widths
interface spa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [spa_pkg::ADDR_W-1:0] free_addr;
  logic                       free_null;

  modport source (output valid, output op, output free_addr, output free_null, input ready);
  modport sink   (input valid, input op, input free_addr, input free_null, output ready);
endinterface

interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::ADDR_W-1:0]   addr;
  logic [spa_pkg::STATUS_W-1:0] status;
  logic                         from_free_list;

  modport source (output valid, output addr, output status, output from_free_list, input ready);
  modport sink   (input valid, input addr, input status, input from_free_list, output ready);
endinterface

// ===== design/spa_link_ram.sv =====
// spa_link_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
module spa_link_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spa_cfg_regs.sv =====
// spa_cfg_regs: apb register file holding slot size and block slot count
// depends on spa_pkg
module spa_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::APB_AW-1:0]  paddr,
  input  logic [spa_pkg::APB_DW-1:0]  pwdata,
  output logic [spa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output spa_pkg::cfg_t               cfg_o
);

  spa_pkg::cfg_t cfg_q;
  spa_pkg::reg_e reg_sel;
  logic          wr_en;

  assign reg_sel = spa_pkg::reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_units  <= spa_pkg::SLOT_UNITS_RST;
      cfg_q.block_slots <= spa_pkg::BLOCK_SLOTS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        spa_pkg::REG_SLOT_UNITS:  cfg_q.slot_units  <= pwdata[spa_pkg::STEP_W-1:0];
        spa_pkg::REG_BLOCK_SLOTS: cfg_q.block_slots <= pwdata[spa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      spa_pkg::REG_SLOT_UNITS:  prdata = spa_pkg::APB_DW'(cfg_q.slot_units);
      spa_pkg::REG_BLOCK_SLOTS: prdata = spa_pkg::APB_DW'(cfg_q.block_slots);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/spa_ctrl.sv =====
// spa_ctrl: request sequencer, free list head, bump pointer and response register
// depends on spa_pkg, spa_if and the link ram ports
module spa_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spa_pkg::cfg_t               cfg_i,
  spa_req_if.sink                     req_i,
  spa_rsp_if.source                   rsp_o,
  output logic                        ram_we_o,
  output logic [spa_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [spa_pkg::LINK_W-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [spa_pkg::ADDR_W-1:0]  ram_raddr_o,
  input  logic [spa_pkg::LINK_W-1:0]  ram_rdata_i
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                      state_q, state_d;
  logic                        op_q;
  logic [spa_pkg::ADDR_W-1:0]  fa_q;
  logic                        fnull_q;
  logic [spa_pkg::PROD_W-1:0]  prod_q;
  logic [spa_pkg::PTR_W-1:0]   bump_q, bump_d;
  logic [spa_pkg::PTR_W-1:0]   end_q, end_d;
  logic [spa_pkg::PTR_W-1:0]   next_q, next_d;
  logic [spa_pkg::ADDR_W-1:0]  head_q, head_d;
  logic                        empty_q, empty_d;
  logic                        out_valid_q, out_valid_d;
  logic [spa_pkg::ADDR_W-1:0]  out_addr_q, out_addr_d;
  spa_pkg::status_e            out_status_q, out_status_d;
  logic                        out_ffl_q, out_ffl_d;

  logic [spa_pkg::STEP_W-1:0]  step;
  logic [spa_pkg::CNT_W-1:0]   count;
  logic                        accept;
  logic                        go;
  logic [spa_pkg::PTR_W:0]     bump_next;
  logic [spa_pkg::PTR_W:0]     base_next;
  logic [spa_pkg::END_W-1:0]   end_sum;
  logic [spa_pkg::PTR_W-1:0]   end_clip;
  logic                        used_up;
  logic                        fits;

  assign step  = (cfg_i.slot_units == '0) ? spa_pkg::STEP_W'(1) : cfg_i.slot_units;
  assign count = (cfg_i.block_slots == '0) ? spa_pkg::CNT_W'(1) : cfg_i.block_slots;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign go          = (state_q == S_EXEC) & (~out_valid_q | rsp_o.ready);

  // free list pop reads the head link; sequencing keeps writes and reads apart
  assign ram_re_o    = accept;
  assign ram_raddr_o = head_q;
  assign ram_we_o    = go & (op_q == spa_pkg::OP_FREE) & ~fnull_q;
  assign ram_waddr_o = fa_q;
  assign ram_wdata_o = {empty_q, head_q};

  assign bump_next = {1'b0, bump_q} + (spa_pkg::PTR_W + 1)'(step);
  assign base_next = {1'b0, next_q} + (spa_pkg::PTR_W + 1)'(step);
  assign used_up   = bump_next > {1'b0, end_q};
  assign fits      = base_next <= (spa_pkg::PTR_W + 1)'(spa_pkg::POOL_UNITS);
  assign end_sum   = spa_pkg::END_W'(next_q) + spa_pkg::END_W'(prod_q);
  assign end_clip  = (end_sum > spa_pkg::END_W'(spa_pkg::POOL_UNITS))
                     ? spa_pkg::PTR_W'(spa_pkg::POOL_UNITS) : end_sum[spa_pkg::PTR_W-1:0];

  always_comb begin
    state_d      = state_q;
    bump_d       = bump_q;
    end_d        = end_q;
    next_d       = next_q;
    head_d       = head_q;
    empty_d      = empty_q;
    out_valid_d  = out_valid_q & ~rsp_o.ready;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_ffl_d    = out_ffl_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_d      = S_IDLE;
          out_valid_d  = 1'b1;
          out_addr_d   = '0;
          out_ffl_d    = 1'b0;
          if (op_q == spa_pkg::OP_FREE) begin
            if (fnull_q) begin
              out_status_d = spa_pkg::ST_NULL;
            end else begin
              out_status_d = spa_pkg::ST_FREED;
              head_d       = fa_q;
              empty_d      = 1'b0;
            end
          end else if (!empty_q) begin
            out_status_d = spa_pkg::ST_ALLOC;
            out_addr_d   = head_q;
            out_ffl_d    = 1'b1;
            head_d       = ram_rdata_i[spa_pkg::ADDR_W-1:0];
            empty_d      = ram_rdata_i[spa_pkg::ADDR_W];
          end else if (used_up) begin
            if (fits) begin
              out_status_d = spa_pkg::ST_ALLOC;
              out_addr_d   = next_q[spa_pkg::ADDR_W-1:0];
              bump_d       = base_next[spa_pkg::PTR_W-1:0];
              end_d        = end_clip;
              next_d       = end_clip;
            end else begin
              out_status_d = spa_pkg::ST_OOM;
            end
          end else begin
            out_status_d = spa_pkg::ST_ALLOC;
            out_addr_d   = bump_q[spa_pkg::ADDR_W-1:0];
            bump_d       = bump_next[spa_pkg::PTR_W-1:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bump_q      <= '0;
      end_q       <= '0;
      next_q      <= '0;
      head_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      end_q       <= end_d;
      next_q      <= next_d;
      head_q      <= head_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_i.op;
      fa_q    <= req_i.free_addr;
      fnull_q <= req_i.free_null;
      prod_q  <= spa_pkg::PROD_W'(count) * spa_pkg::PROD_W'(step);
    end
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_ffl_q    <= out_ffl_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.addr           = out_addr_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.from_free_list = out_ffl_q;

endmodule

// ===== design/slot_pool_allocator.sv =====
// slot_pool_allocator: a request is taken in S_IDLE and executed in S_EXEC, so the next request
// waits until it has executed; the link ram read registers the head link before the head can move
// the result beat is registered when S_EXEC executes, which waits while a response beat stalls
// a new request is taken while the previous result beat still waits in its register
// reset clears the pointers and empties the free list; the link ram needs no clearing
// depends on spa_pkg, spa_if, spa_cfg_regs, spa_ctrl and spa_link_ram
module slot_pool_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  spa_req_if.sink                     req_i,
  spa_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spa_pkg::APB_AW-1:0]  paddr,
  input  logic [spa_pkg::APB_DW-1:0]  pwdata,
  output logic [spa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  spa_pkg::cfg_t               cfg;
  logic                        ram_we;
  logic [spa_pkg::ADDR_W-1:0]  ram_waddr;
  logic [spa_pkg::LINK_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [spa_pkg::ADDR_W-1:0]  ram_raddr;
  logic [spa_pkg::LINK_W-1:0]  ram_rdata;

  spa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  spa_link_ram #(
    .WIDTH (spa_pkg::LINK_W),
    .DEPTH (spa_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== design/spa_checker.sv =====
// spa_checker: port-level assertions for slot_pool_allocator and its bind
// depends on spa_pkg
module spa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [spa_pkg::ADDR_W-1:0]   rsp_addr_i,
  input logic [spa_pkg::STATUS_W-1:0] rsp_status_i,
  input logic                         rsp_ffl_i
);

  logic req_beat;

  assign req_beat = req_valid_i & req_ready_i;

  // after a request beat the sequencer is busy in S_EXEC and takes no new request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_beat |=> !req_ready_i)
    else $error("request taken in the cycle after a request beat");

  // a fresh result appears only after a request beat has been executed in S_EXEC
  a_rsp_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_beat, 2))
    else $error("result beat without a preceding request beat");

  // reuse from the free list is only reported for allocations
  a_ffl_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_ffl_i) |-> (rsp_status_i == spa_pkg::ST_ALLOC))
    else $error("free list flag on a non-allocation result");

  // non-allocation results carry a zero address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != spa_pkg::ST_ALLOC)) |-> (rsp_addr_i == '0))
    else $error("nonzero address on a non-allocation result");

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_addr_i)
      && $stable(rsp_status_i) && $stable(rsp_ffl_i)))
    else $error("stalled result beat changed");

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_addr_i   (rsp_o.addr),
  .rsp_status_i (rsp_o.status),
  .rsp_ffl_i    (rsp_o.from_free_list)
);
